// ===== design/pbp_pkg.sv =====
// ============================================================================
// pbp_pkg
// Shared types, widths and saturation helpers for the product bounds
// propagator.
// ============================================================================
package pbp_pkg;

    // value width of every bound
    localparam int VW      = 32;
    // divider latency: operand stage, one stage per quotient bit, fix-up stage
    localparam int DIV_LAT = VW + 2;

    localparam logic signed [VW-1:0] V_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] V_MIN = {1'b1, {(VW-1){1'b0}}};

    typedef struct packed {
        logic signed [VW-1:0] x_low_in;
        logic signed [VW-1:0] x_high_in;
        logic signed [VW-1:0] y_low_in;
        logic signed [VW-1:0] y_high_in;
        logic signed [VW-1:0] z_low_in;
        logic signed [VW-1:0] z_high_in;
    } t_in_item;

    typedef struct packed {
        logic signed [VW-1:0] z_low_out;
        logic signed [VW-1:0] z_high_out;
        logic signed [VW-1:0] x_low_out;
        logic signed [VW-1:0] x_high_out;
        logic                 x_bounds_apply;
        logic signed [VW-1:0] y_low_out;
        logic signed [VW-1:0] y_high_out;
        logic                 y_bounds_apply;
    } t_out_item;

    // floor and ceiling quotient from one divider
    typedef struct packed {
        logic signed [VW-1:0] q_floor;
        logic signed [VW-1:0] q_ceil;
    } t_quot;

    // clamp a full product to the value range
    function automatic logic signed [VW-1:0] sat_prod(input logic signed [2*VW-1:0] v);
        logic signed [2*VW-1:0] hi;
        logic signed [2*VW-1:0] lo;
        hi = (2*VW)'(V_MAX);
        lo = (2*VW)'(V_MIN);
        if (v > hi) begin
            return V_MAX;
        end else if (v < lo) begin
            return V_MIN;
        end
        return v[VW-1:0];
    endfunction

    // clamp a one-bit-wider quotient to the value range
    function automatic logic signed [VW-1:0] sat_quot(input logic signed [VW:0] v);
        logic signed [VW:0] hi;
        logic signed [VW:0] lo;
        hi = (VW+1)'(V_MAX);
        lo = (VW+1)'(V_MIN);
        if (v > hi) begin
            return V_MAX;
        end else if (v < lo) begin
            return V_MIN;
        end
        return v[VW-1:0];
    endfunction

    function automatic logic signed [VW-1:0] min4(input logic signed [VW-1:0] a,
                                                   input logic signed [VW-1:0] b,
                                                   input logic signed [VW-1:0] c,
                                                   input logic signed [VW-1:0] d);
        logic signed [VW-1:0] m0;
        logic signed [VW-1:0] m1;
        m0 = (b < a) ? b : a;
        m1 = (d < c) ? d : c;
        return (m1 < m0) ? m1 : m0;
    endfunction

    function automatic logic signed [VW-1:0] max4(input logic signed [VW-1:0] a,
                                                   input logic signed [VW-1:0] b,
                                                   input logic signed [VW-1:0] c,
                                                   input logic signed [VW-1:0] d);
        logic signed [VW-1:0] m0;
        logic signed [VW-1:0] m1;
        m0 = (b > a) ? b : a;
        m1 = (d > c) ? d : c;
        return (m1 > m0) ? m1 : m0;
    endfunction

endpackage

// ===== design/pbp_mul.sv =====
// ============================================================================
// pbp_mul
// Two-stage signed multiplier: full product, then saturation to value width.
// ============================================================================
module pbp_mul (
    input  logic                           i_clk,
    input  logic signed [pbp_pkg::VW-1:0]  i_a,
    input  logic signed [pbp_pkg::VW-1:0]  i_b,
    output logic signed [pbp_pkg::VW-1:0]  o_prod
);
    import pbp_pkg::*;

    logic signed [2*VW-1:0] r_prod;
    logic signed [VW-1:0]   r_sat;

    // multiply, then clamp
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        r_sat  <= sat_prod(r_prod);
    end

    assign o_prod = r_sat;

endmodule

// ===== design/pbp_div.sv =====
// ============================================================================
// pbp_div
// Pipelined restoring divider, one quotient bit per stage, giving the floor
// and ceiling quotients saturated to value width. A zero divisor counts as 1.
// ============================================================================
module pbp_div (
    input  logic                           i_clk,
    input  logic signed [pbp_pkg::VW-1:0]  i_num,
    input  logic signed [pbp_pkg::VW-1:0]  i_den,
    output pbp_pkg::t_quot                 o_quot
);
    import pbp_pkg::*;

    logic [VW-1:0] r_rem [VW+1];
    logic [VW-1:0] r_quo [VW+1];
    logic [VW-1:0] r_den [VW+1];
    logic          r_neg [VW+1];
    t_quot         r_out;

    logic signed [VW-1:0] den_fix;
    logic signed [VW:0]   fq;
    logic signed [VW:0]   rz;
    logic signed [VW:0]   floor_v;
    logic signed [VW:0]   ceil_v;

    assign den_fix = (i_den == '0) ? VW'(1) : i_den;

    // take signs and magnitudes
    always_ff @(posedge i_clk) begin
        r_rem[0] <= '0;
        r_quo[0] <= i_num[VW-1] ? VW'(-i_num) : i_num;
        r_den[0] <= den_fix[VW-1] ? VW'(-den_fix) : den_fix;
        r_neg[0] <= i_num[VW-1] ^ den_fix[VW-1];
    end

    // one quotient bit per stage
    for (genvar k = 0; k < VW; k++) begin : g_step
        logic [VW:0] t;
        logic [VW:0] diff;
        logic        ge;
        assign t    = {r_rem[k], r_quo[k][VW-1]};
        assign diff = t - {1'b0, r_den[k]};
        assign ge   = (t >= {1'b0, r_den[k]});
        always_ff @(posedge i_clk) begin
            r_rem[k+1] <= ge ? diff[VW-1:0] : t[VW-1:0];
            r_quo[k+1] <= {r_quo[k][VW-2:0], ge};
            r_den[k+1] <= r_den[k];
            r_neg[k+1] <= r_neg[k];
        end
    end

    // round toward floor and ceiling from truncated magnitude
    assign fq      = {1'b0, r_quo[VW]};
    assign rz      = (VW+1)'(|r_rem[VW]);
    assign floor_v = r_neg[VW] ? (-fq - rz) : fq;
    assign ceil_v  = r_neg[VW] ? (-fq) : (fq + rz);

    always_ff @(posedge i_clk) begin
        r_out.q_floor <= sat_quot(floor_v);
        r_out.q_ceil  <= sat_quot(ceil_v);
    end

    assign o_quot = r_out;

endmodule

// ===== design/pbp_delay.sv =====
// ============================================================================
// pbp_delay
// Fixed-depth shift line that keeps side data aligned with the dividers.
// ============================================================================
module pbp_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic [WIDTH-1:0] i_data,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_tap [DEPTH];

    // advance every tap each cycle
    always_ff @(posedge i_clk) begin
        r_tap[0] <= i_data;
        for (int k = 1; k < DEPTH; k++) begin
            r_tap[k] <= r_tap[k-1];
        end
    end

    assign o_data = r_tap[DEPTH-1];

endmodule

// ===== design/product_bounds_propagator.sv =====
// ============================================================================
// product_bounds_propagator
// Bounds propagation for x*y=z: corner-product hull for z, quotient bounds
// for x and y when the other factor's range excludes zero.
// ============================================================================
//   channel   handshake        payload      direction
//   item in   start / busy     i_item       in
//   result    o_done strobe    o_result     out
//
// One word enters per cycle; busy stays low. Each result passes the input
// register, the divider pipeline of one stage per quotient bit and the
// result register. Reset clears only the valid chain.
// The receiver takes o_result in the cycle o_done is high.
module product_bounds_propagator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  pbp_pkg::t_in_item  i_item,
    output logic               o_done,
    output pbp_pkg::t_out_item o_result
);
    import pbp_pkg::*;

    localparam int HULL_LAT = 3;
    localparam int ZDLY     = DIV_LAT - HULL_LAT;

    logic [DIV_LAT+1:0]   r_vld;
    t_in_item             r_in;
    logic signed [VW-1:0] prod [4];
    logic signed [VW-1:0] r_zlo;
    logic signed [VW-1:0] r_zhi;
    logic [2*VW-1:0]      z_dly;
    logic [1:0]           flag_dly;
    logic                 x_app;
    logic                 y_app;
    t_quot                qx [4];
    t_quot                qy [4];
    t_out_item            r_res;

    assign busy = 1'b0;

    // advance valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[DIV_LAT:0], start & ~busy};
        end
    end

    // capture input word
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_in <= i_item;
        end
    end

    // corner products
    pbp_mul u_mul0 (.i_clk(i_clk), .i_a(r_in.x_low_in),  .i_b(r_in.y_low_in),  .o_prod(prod[0]));
    pbp_mul u_mul1 (.i_clk(i_clk), .i_a(r_in.x_low_in),  .i_b(r_in.y_high_in), .o_prod(prod[1]));
    pbp_mul u_mul2 (.i_clk(i_clk), .i_a(r_in.x_high_in), .i_b(r_in.y_low_in),  .o_prod(prod[2]));
    pbp_mul u_mul3 (.i_clk(i_clk), .i_a(r_in.x_high_in), .i_b(r_in.y_high_in), .o_prod(prod[3]));

    // hull of corners
    always_ff @(posedge i_clk) begin
        r_zlo <= min4(prod[0], prod[1], prod[2], prod[3]);
        r_zhi <= max4(prod[0], prod[1], prod[2], prod[3]);
    end

    pbp_delay #(.WIDTH(2*VW), .DEPTH(ZDLY)) u_zdly (
        .i_clk (i_clk),
        .i_data({r_zlo, r_zhi}),
        .o_data(z_dly)
    );

    // apply flags travel beside the dividers
    assign x_app = (r_in.y_low_in > 0) || (r_in.y_high_in < 0);
    assign y_app = (r_in.x_low_in > 0) || (r_in.x_high_in < 0);

    pbp_delay #(.WIDTH(2), .DEPTH(DIV_LAT)) u_fdly (
        .i_clk (i_clk),
        .i_data({x_app, y_app}),
        .o_data(flag_dly)
    );

    // quotients of z bounds by y bounds, then by x bounds
    pbp_div u_dx0 (.i_clk(i_clk), .i_num(r_in.z_low_in),  .i_den(r_in.y_low_in),  .o_quot(qx[0]));
    pbp_div u_dx1 (.i_clk(i_clk), .i_num(r_in.z_low_in),  .i_den(r_in.y_high_in), .o_quot(qx[1]));
    pbp_div u_dx2 (.i_clk(i_clk), .i_num(r_in.z_high_in), .i_den(r_in.y_low_in),  .o_quot(qx[2]));
    pbp_div u_dx3 (.i_clk(i_clk), .i_num(r_in.z_high_in), .i_den(r_in.y_high_in), .o_quot(qx[3]));
    pbp_div u_dy0 (.i_clk(i_clk), .i_num(r_in.z_low_in),  .i_den(r_in.x_low_in),  .o_quot(qy[0]));
    pbp_div u_dy1 (.i_clk(i_clk), .i_num(r_in.z_low_in),  .i_den(r_in.x_high_in), .o_quot(qy[1]));
    pbp_div u_dy2 (.i_clk(i_clk), .i_num(r_in.z_high_in), .i_den(r_in.x_low_in),  .o_quot(qy[2]));
    pbp_div u_dy3 (.i_clk(i_clk), .i_num(r_in.z_high_in), .i_den(r_in.x_high_in), .o_quot(qy[3]));

    // pick extreme quotients, drop bounds that do not apply
    always_ff @(posedge i_clk) begin
        r_res.z_low_out      <= z_dly[2*VW-1:VW];
        r_res.z_high_out     <= z_dly[VW-1:0];
        r_res.x_bounds_apply <= flag_dly[1];
        r_res.y_bounds_apply <= flag_dly[0];
        r_res.x_low_out  <= flag_dly[1] ?
            min4(qx[0].q_ceil, qx[1].q_ceil, qx[2].q_ceil, qx[3].q_ceil) : '0;
        r_res.x_high_out <= flag_dly[1] ?
            max4(qx[0].q_floor, qx[1].q_floor, qx[2].q_floor, qx[3].q_floor) : '0;
        r_res.y_low_out  <= flag_dly[0] ?
            min4(qy[0].q_ceil, qy[1].q_ceil, qy[2].q_ceil, qy[3].q_ceil) : '0;
        r_res.y_high_out <= flag_dly[0] ?
            max4(qy[0].q_floor, qy[1].q_floor, qy[2].q_floor, qy[3].q_floor) : '0;
    end

    assign o_done   = r_vld[DIV_LAT+1];
    assign o_result = r_res;

endmodule

// ===== verif/tb_top.sv =====
// ============================================================================
// tb_top
// Self-checking bench for product_bounds_propagator: directed corner words,
// then random bound tuples, checked against an in-bench bounds predictor.
// ============================================================================
module tb_top;
    import pbp_pkg::*;

    localparam int LATENCY  = DIV_LAT + 2;
    localparam int WD_LIMIT = 4 * LATENCY + 200;
    localparam int N_RANDOM = 1430;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    t_in_item  i_item = '0;
    logic      o_done;
    t_out_item o_result;

    t_out_item bounds_q[$];
    int        n_errors = 0;
    int        idle_cycles = 0;
    bit        allow_gaps = 1'b1;

    product_bounds_propagator i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_done(o_done), .o_result(o_result)
    );

    always #2 i_clk = ~i_clk;

    // saturate a wide value to the value range
    function automatic logic signed [VW-1:0] clamp_wide(input longint v);
        if (v > longint'(V_MAX)) return V_MAX;
        if (v < longint'(V_MIN)) return V_MIN;
        return v[VW-1:0];
    endfunction

    function automatic longint div_floor(input longint a, input longint b);
        longint q;
        if (b == 0) b = 1;
        q = a / b;
        if ((a % b != 0) && ((a < 0) != (b < 0))) q--;
        return q;
    endfunction

    function automatic longint div_ceil(input longint a, input longint b);
        longint q;
        if (b == 0) b = 1;
        q = a / b;
        if ((a % b != 0) && ((a < 0) == (b < 0))) q++;
        return q;
    endfunction

    // new factor bounds from z range and the other factor's range
    function automatic void factor_bounds(input longint zl, input longint zh, input longint dl,
                                          input longint dh, output logic signed [VW-1:0] lo,
                                          output logic signed [VW-1:0] hi);
        longint c[4];
        longint f[4];
        longint mn;
        longint mx;
        c[0] = div_ceil(zl, dl);  c[1] = div_ceil(zl, dh);
        c[2] = div_ceil(zh, dl);  c[3] = div_ceil(zh, dh);
        f[0] = div_floor(zl, dl); f[1] = div_floor(zl, dh);
        f[2] = div_floor(zh, dl); f[3] = div_floor(zh, dh);
        mn = c[0];
        mx = f[0];
        for (int k = 1; k < 4; k++) begin
            if (c[k] < mn) mn = c[k];
            if (f[k] > mx) mx = f[k];
        end
        lo = clamp_wide(mn);
        hi = clamp_wide(mx);
    endfunction

    function automatic t_out_item predict_bounds(input t_in_item w);
        t_out_item r;
        longint xl, xh, yl, yh, zl, zh;
        longint p[4];
        longint mn;
        longint mx;
        xl = longint'(w.x_low_in);  xh = longint'(w.x_high_in);
        yl = longint'(w.y_low_in);  yh = longint'(w.y_high_in);
        zl = longint'(w.z_low_in);  zh = longint'(w.z_high_in);
        // 32x32 products fit in 64 bits
        p[0] = xl * yl; p[1] = xl * yh; p[2] = xh * yl; p[3] = xh * yh;
        mn = p[0];
        mx = p[0];
        for (int k = 1; k < 4; k++) begin
            if (p[k] < mn) mn = p[k];
            if (p[k] > mx) mx = p[k];
        end
        r = '0;
        r.z_low_out  = clamp_wide(mn);
        r.z_high_out = clamp_wide(mx);
        r.x_bounds_apply = (yl > 0) || (yh < 0);
        r.y_bounds_apply = (xl > 0) || (xh < 0);
        if (r.x_bounds_apply) factor_bounds(zl, zh, yl, yh, r.x_low_out, r.x_high_out);
        if (r.y_bounds_apply) factor_bounds(zl, zh, xl, xh, r.y_low_out, r.y_high_out);
        return r;
    endfunction

    // send one word, with an optional random gap first
    task automatic send_word(input t_in_item w);
        if (allow_gaps && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= w;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        bounds_q.push_back(predict_bounds(w));
        @(negedge i_clk);
    endtask

    task automatic send_idle();
        start <= 1'b0;
    endtask

    function automatic logic signed [VW-1:0] rand_value();
        case ($urandom_range(0, 5))
            0: return V_MAX - $urandom_range(0, 3);
            1: return V_MIN + $urandom_range(0, 3);
            2: return $urandom_range(0, 20) - 10;
            3: return $urandom_range(0, 4000) - 2000;
            4: return $urandom_range(0, 200000) - 100000;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in_item rand_word();
        t_in_item w;
        logic signed [VW-1:0] a, b;
        w.x_low_in = rand_value(); w.x_high_in = rand_value();
        w.y_low_in = rand_value(); w.y_high_in = rand_value();
        w.z_low_in = rand_value(); w.z_high_in = rand_value();
        // mostly ordered ranges; leave some inverted
        if ($urandom_range(0, 7) != 0) begin
            a = w.x_low_in; b = w.x_high_in;
            if (a > b) begin w.x_low_in = b; w.x_high_in = a; end
            a = w.y_low_in; b = w.y_high_in;
            if (a > b) begin w.y_low_in = b; w.y_high_in = a; end
            a = w.z_low_in; b = w.z_high_in;
            if (a > b) begin w.z_low_in = b; w.z_high_in = a; end
        end
        return w;
    endfunction

    function automatic t_in_item make_word(input logic signed [VW-1:0] xl, xh, yl, yh, zl, zh);
        t_in_item w;
        w.x_low_in = xl; w.x_high_in = xh;
        w.y_low_in = yl; w.y_high_in = yh;
        w.z_low_in = zl; w.z_high_in = zh;
        return w;
    endfunction

    // corners: extremes, overflow, min/-1, straddling zero, inverted with zero divisor
    task automatic test_directed();
        send_word(make_word('0, '0, '0, '0, '0, '0));
        send_word(make_word(V_MAX, V_MAX, V_MAX, V_MAX, V_MAX, V_MAX));
        send_word(make_word(V_MIN, V_MIN, V_MIN, V_MIN, V_MIN, V_MIN));
        send_word(make_word(V_MIN, V_MAX, V_MIN, V_MAX, V_MIN, V_MAX));
        send_word(make_word(2, 5, 3, 7, 10, 30));
        send_word(make_word(-5, -2, -7, -3, -30, 31));
        send_word(make_word(-1, -1, -1, -1, V_MIN, V_MIN));
        send_word(make_word(V_MIN, V_MIN, -1, -1, V_MIN, V_MAX));
        send_word(make_word(-3, 4, 2, 9, -17, 23));
        send_word(make_word(3, 4, -2, 9, -17, 23));
        send_word(make_word(5, -5, 3, 1, -7, 8));
        send_word(make_word(1, 0, 0, -1, 9, -9));
        send_word(make_word(0, -2, 2, 0, 13, 13));
        send_word(make_word(65536, 65536, 65536, 65536, 1, 1));
        send_word(make_word(-65536, 65536, 32768, 65537, V_MIN, V_MAX));
        send_word(make_word(1, 1, V_MIN, V_MAX, V_MIN, 7));
        send_word(make_word(-32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1));
    endtask

    task automatic test_random();
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n > N_RANDOM - 200) allow_gaps = 1'b0;
            send_word(rand_word());
        end
        send_idle();
    endtask

    // check each result strobe against the oldest prediction
    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n && o_done) begin
            if (bounds_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_result);
                n_errors++;
            end else begin
                e = bounds_q.pop_front();
                if (e.z_low_out != o_result.z_low_out)
                    $display("%0t: z_low exp %0d got %0d", $time, e.z_low_out, o_result.z_low_out);
                if (e.z_high_out != o_result.z_high_out)
                    $display("%0t: z_high exp %0d got %0d", $time, e.z_high_out,
                             o_result.z_high_out);
                if (e.x_low_out != o_result.x_low_out)
                    $display("%0t: x_low exp %0d got %0d", $time, e.x_low_out, o_result.x_low_out);
                if (e.x_high_out != o_result.x_high_out)
                    $display("%0t: x_high exp %0d got %0d", $time, e.x_high_out,
                             o_result.x_high_out);
                if (e.x_bounds_apply !== o_result.x_bounds_apply)
                    $display("%0t: x_apply exp %0b got %0b", $time, e.x_bounds_apply,
                             o_result.x_bounds_apply);
                if (e.y_low_out != o_result.y_low_out)
                    $display("%0t: y_low exp %0d got %0d", $time, e.y_low_out, o_result.y_low_out);
                if (e.y_high_out != o_result.y_high_out)
                    $display("%0t: y_high exp %0d got %0d", $time, e.y_high_out,
                             o_result.y_high_out);
                if (e.y_bounds_apply !== o_result.y_bounds_apply)
                    $display("%0t: y_apply exp %0b got %0b", $time, e.y_bounds_apply,
                             o_result.y_bounds_apply);
                if (e !== o_result) n_errors++;
            end
        end
    end

    // watchdog: count cycles with no word moving either way
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WD_LIMIT) begin
                $display("FAIL product_bounds_propagator");
                $finish;
            end
        end
    end

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random();
        while (bounds_q.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
        if (n_errors == 0 && bounds_q.size() == 0) begin
            $display("PASS product_bounds_propagator");
        end else begin
            $display("FAIL product_bounds_propagator");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/pbp_pkg.sv
design/pbp_mul.sv
design/pbp_div.sv
design/pbp_delay.sv
design/product_bounds_propagator.sv
verif/tb_top.sv
